// ----- rtl/rlb_pkg.sv -----
// Shared types, codes and digit decoding for the radix literal converter.
`default_nettype none

package rlb_pkg;

   localparam int CHAR_W    = 8;
   localparam int VALUE_W   = 64;
   localparam int WIDTH_W   = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Largest decimal value that still fits a signed 64-bit result.
   localparam logic [VALUE_W-1:0] DEC_LIMIT = {1'b0, {(VALUE_W-1){1'b1}}};

   typedef enum logic [1:0] {
      RADIX_BIN = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_DEC = 2'd2,
      RADIX_HEX = 2'd3
   } radix_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_DIGIT = 2'd1,
      ST_RANGE     = 2'd2
   } status_type;

   typedef enum logic {
      REG_RADIX = 1'b0,
      REG_WIDTH = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } digit_type;

   // Decode one ASCII character into a digit of the given radix.
   function automatic digit_type digit_of(input logic [CHAR_W-1:0] ch,
                                          input radix_type radix);
      digit_type d;
      d.ok  = 1'b0;
      d.val = 4'd0;
      if (ch inside {[8'h30:8'h39]}) begin
         d.ok  = 1'b1;
         d.val = 4'(ch - 8'h30);
      end else if (ch inside {[8'h61:8'h66]}) begin
         d.ok  = 1'b1;
         d.val = 4'(ch - 8'h61 + 8'd10);
      end else if (ch inside {[8'h41:8'h46]}) begin
         d.ok  = 1'b1;
         d.val = 4'(ch - 8'h41 + 8'd10);
      end
      case (radix)
         RADIX_BIN: if (d.val > 4'd1) d.ok = 1'b0;
         RADIX_OCT: if (d.val > 4'd7) d.ok = 1'b0;
         RADIX_DEC: if (d.val > 4'd9) d.ok = 1'b0;
         default:   d.ok = d.ok;
      endcase
      return d;
   endfunction

   // Keep the low w bits; zero keeps nothing, 64 and above keep all.
   function automatic logic [VALUE_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
      logic [VALUE_W-1:0] m;
      if (w >= WIDTH_W'(VALUE_W)) begin
         m = '1;
      end else begin
         m = ~({VALUE_W{1'b1}} << w[5:0]);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/rlb_req_if.sv -----
// Character channel interface: one ASCII character per transfer.
`default_nettype none

interface rlb_req_if;
   logic                         valid;
   logic                         ready;
   logic [rlb_pkg::CHAR_W-1:0]   char_code;
   logic                         is_last;

   modport source (output valid, output char_code, output is_last, input ready);
   modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/rlb_rsp_if.sv -----
// Result channel interface: converted value and status per transfer.
`default_nettype none

interface rlb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rlb_pkg::VALUE_W-1:0]   value;
   logic [1:0]                    status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/radix_literal_to_binary.sv -----
// Top level: ASCII radix literal to binary converter.
//
//   channel   direction  payload                       transfer when
//   req_in    in         char_code[7:0], is_last       valid & ready
//   rsp_out   out        value[63:0], status[1:0]      valid & ready
//   APB csr   in/out     radix_select @0, width @4     psel & penable & pwrite
//
// One character per cycle unless a final one waits on a stalled result: a character
// waits in the input register, then the times-ten add (or shift) updates the accumulator.
// A final character passes from the input register into the result register.
// Reset is synchronous; it clears the pipeline, the accumulator and the
// registers to decimal radix and 32-bit width. A stalled result holds the
// result register; only a final character behind it waits, others go on.
`default_nettype none

module radix_literal_to_binary (
   input  wire logic                              clock,
   input  wire logic                              reset,
   rlb_req_if.sink                                req_in,
   rlb_rsp_if.source                              rsp_out,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [rlb_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [rlb_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [rlb_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                   pready
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   rlb_pkg::radix_type                 radix_ff;
   logic [rlb_pkg::WIDTH_W-1:0]        width_ff;
   logic                               csr_write;
   rlb_pkg::csr_reg_type               csr_sel;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   // Registers sit on a 4-byte stride; bit 2 picks the register.
   assign csr_sel   = rlb_pkg::csr_reg_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= rlb_pkg::RADIX_DEC;
         width_ff <= rlb_pkg::WIDTH_W'(32);
      end else if (csr_write) begin
         case (csr_sel)
            rlb_pkg::REG_RADIX: radix_ff <= rlb_pkg::radix_type'(pwdata[1:0]);
            rlb_pkg::REG_WIDTH: width_ff <= pwdata[rlb_pkg::WIDTH_W-1:0];
            default:            radix_ff <= radix_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         rlb_pkg::REG_RADIX: prdata = rlb_pkg::CSR_DATA_W'(radix_ff);
         rlb_pkg::REG_WIDTH: prdata = rlb_pkg::CSR_DATA_W'(width_ff);
         default:            prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Handshake control
   // ---------------------------------------------------------------------
   logic                               s1_valid_ff, s1_valid_in;
   logic [rlb_pkg::CHAR_W-1:0]         s1_char_ff;
   logic                               s1_last_ff;
   logic                               out_valid_ff, out_valid_in;
   logic [rlb_pkg::VALUE_W-1:0]        out_value_ff, out_value_in;
   rlb_pkg::status_type                out_status_ff, out_status_in;
   logic                               req_xfer, proc, out_load;

   // Advance the held character unless it is final and the result slot is busy.
   assign proc     = s1_valid_ff && (!s1_last_ff || !out_valid_ff || rsp_out.ready);
   assign out_load = proc && s1_last_ff;

   assign req_in.ready = !s1_valid_ff || proc;
   assign req_xfer     = req_in.valid && req_in.ready;

   assign s1_valid_in  = req_xfer || (s1_valid_ff && !proc);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_out.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register: payload only, loaded on each character transfer.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_char_ff <= req_in.char_code;
         s1_last_ff <= req_in.is_last;
      end
   end

   // ---------------------------------------------------------------------
   // Digit decode and accumulate
   // ---------------------------------------------------------------------
   logic [rlb_pkg::VALUE_W-1:0]        acc_ff, acc_in;
   rlb_pkg::status_type                err_ff, err_in;
   rlb_pkg::digit_type                 dig;
   logic [rlb_pkg::VALUE_W+3:0]        dec_sum;
   logic                               dec_over;
   logic [rlb_pkg::VALUE_W-1:0]        mask;

   assign dig = rlb_pkg::digit_of(s1_char_ff, radix_ff);

   // acc*10 + d as (acc<<3) + (acc<<1) + d, wide enough to never wrap.
   assign dec_sum  = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1)
                   + (rlb_pkg::VALUE_W+4)'(dig.val);
   assign dec_over = dec_sum > (rlb_pkg::VALUE_W+4)'(rlb_pkg::DEC_LIMIT);

   assign mask = rlb_pkg::width_mask(width_ff);

   always_comb begin
      acc_in = acc_ff;
      err_in = err_ff;
      if (!dig.ok) begin
         // Bad digit wins over any earlier status and adds nothing.
         err_in = rlb_pkg::ST_BAD_DIGIT;
      end else begin
         case (radix_ff)
            rlb_pkg::RADIX_DEC: begin
               // Freeze the decimal value once any error is pending.
               if (err_ff == rlb_pkg::ST_OK) begin
                  if (dec_over) begin
                     err_in = rlb_pkg::ST_RANGE;
                  end else begin
                     acc_in = dec_sum[rlb_pkg::VALUE_W-1:0];
                  end
               end
            end
            rlb_pkg::RADIX_HEX: acc_in = {acc_ff[rlb_pkg::VALUE_W-5:0], dig.val};
            rlb_pkg::RADIX_OCT: acc_in = {acc_ff[rlb_pkg::VALUE_W-4:0], dig.val[2:0]};
            rlb_pkg::RADIX_BIN: acc_in = {acc_ff[rlb_pkg::VALUE_W-2:0], dig.val[0]};
            default:            acc_in = acc_ff;
         endcase
      end

      out_status_in = err_in;
      out_value_in  = (err_in == rlb_pkg::ST_OK) ? (acc_in & mask) : '0;
   end

   // Accumulator and sticky status: drop both after the final character.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         err_ff <= rlb_pkg::ST_OK;
      end else if (proc) begin
         if (s1_last_ff) begin
            acc_ff <= '0;
            err_ff <= rlb_pkg::ST_OK;
         end else begin
            acc_ff <= acc_in;
            err_ff <= err_in;
         end
      end
   end

   // Result register: hold while the consumer stalls.
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_value_ff  <= out_value_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_out.valid  = out_valid_ff;
   assign rsp_out.value  = out_value_ff;
   assign rsp_out.status = out_status_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_err_zero_value: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_status_ff != rlb_pkg::ST_OK) |-> out_value_ff == '0)
      else $error("error result carries a nonzero value");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (acc_ff == '0) && (err_ff == rlb_pkg::ST_OK))
      else $error("accumulator not cleared after final character");

   a_width_kept: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (out_value_ff & ~$past(mask)) == '0)
      else $error("result has bits above the configured width");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_out.ready |=> out_valid_ff)
      else $error("stalled result dropped");

endmodule

`default_nettype wire

// ----- verif/radix_literal_to_binary_tb.sv -----
// Self-checking testbench for the radix literal converter: digit stream in, values checked out.
`timescale 1ns / 100ps

module radix_literal_to_binary_tb;

   localparam int CLOCK_HALF    = 4;
   localparam int SETTLE_CYCLES = 6;       // input register plus accumulate, with margin
   localparam int RANDOM_CHARS  = 1650;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int MAX_REPORTS   = 50;

   typedef struct packed {
      logic [rlb_pkg::CHAR_W-1:0] code;
      logic                       is_end;
   } char_item_type;

   typedef struct packed {
      logic [rlb_pkg::VALUE_W-1:0] value;
      rlb_pkg::status_type         status;
   } conversion_type;

   logic                           clock;
   logic                           reset;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [rlb_pkg::CSR_ADDR_W-1:0] paddr;
   logic [rlb_pkg::CSR_DATA_W-1:0] pwdata;
   logic [rlb_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   rlb_req_if req_bus ();
   rlb_rsp_if rsp_bus ();

   radix_literal_to_binary i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_bus),
      .rsp_out (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Characters waiting for the driver, and conversions waiting for the block.
   char_item_type  char_queue[$];
   conversion_type pending_conversions[$];

   // Predictor copy of the registers and of the accumulator.
   rlb_pkg::radix_type          tb_radix;
   logic [rlb_pkg::WIDTH_W-1:0] tb_width;
   logic [rlb_pkg::VALUE_W-1:0] acc_value;
   rlb_pkg::status_type         acc_status;

   int  chars_pushed;
   int  chars_accepted;
   int  results_checked;
   int  bad_digit_results;
   int  range_results;
   int  setting_count;
   int  error_count;
   int  cycle_count;

   // Handshake bookkeeping between the sampling edge and the driving edge.
   logic          char_taken;
   logic          result_taken;
   int            req_gap;
   int            rsp_stall;
   bit            req_burst;
   bit            rsp_burst;
   char_item_type outgoing;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic int radix_base(input rlb_pkg::radix_type radix);
      case (radix)
         rlb_pkg::RADIX_BIN: return 2;
         rlb_pkg::RADIX_OCT: return 8;
         rlb_pkg::RADIX_DEC: return 10;
         default:            return 16;
      endcase
   endfunction

   // Map an ASCII character to its digit; true when the digit fits the radix.
   function automatic bit decode_digit(input logic [rlb_pkg::CHAR_W-1:0] code,
                                       input rlb_pkg::radix_type radix,
                                       output logic [3:0] digit);
      int unsigned v;
      v = 16;
      if (code >= "0" && code <= "9") begin
         v = code - "0";
      end else if (code >= "a" && code <= "f") begin
         v = code - "a" + 10;
      end else if (code >= "A" && code <= "F") begin
         v = code - "A" + 10;
      end
      digit = v[3:0];
      return v < radix_base(radix);
   endfunction

   function automatic logic [rlb_pkg::VALUE_W-1:0] keep_mask(
         input logic [rlb_pkg::WIDTH_W-1:0] w);
      if (w == 0) begin
         return '0;
      end else if (w >= rlb_pkg::VALUE_W) begin
         return '1;
      end
      return (64'd1 << w) - 64'd1;
   endfunction

   // Advance the accumulator by one character; on the end character queue
   // the conversion the block must return and clear for the next literal.
   task automatic convert_char(input logic [rlb_pkg::CHAR_W-1:0] code, input logic is_end);
      logic [3:0]     digit;
      conversion_type done;
      if (!decode_digit(code, tb_radix, digit)) begin
         // Bad digit wins over everything and sticks until the literal ends.
         acc_status = rlb_pkg::ST_BAD_DIGIT;
      end else begin
         case (tb_radix)
            rlb_pkg::RADIX_DEC: begin
               // Freeze the value once any error is pending or it would pass the signed 64-bit maximum.
               if (acc_status == rlb_pkg::ST_OK) begin
                  if (acc_value > (rlb_pkg::DEC_LIMIT - 64'(digit)) / 64'd10) begin
                     acc_status = rlb_pkg::ST_RANGE;
                  end else begin
                     acc_value = acc_value * 64'd10 + 64'(digit);
                  end
               end
            end
            rlb_pkg::RADIX_HEX: acc_value = {acc_value[rlb_pkg::VALUE_W-5:0], digit};
            rlb_pkg::RADIX_OCT: acc_value = {acc_value[rlb_pkg::VALUE_W-4:0], digit[2:0]};
            default:            acc_value = {acc_value[rlb_pkg::VALUE_W-2:0], digit[0]};
         endcase
      end
      if (is_end) begin
         done.value  = (acc_status == rlb_pkg::ST_OK) ? (acc_value & keep_mask(tb_width))
                                                      : '0;
         done.status = acc_status;
         pending_conversions.push_back(done);
         acc_value  = '0;
         acc_status = rlb_pkg::ST_OK;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [rlb_pkg::VALUE_W-1:0] got,
                                  input logic [rlb_pkg::VALUE_W-1:0] want);
      if (error_count < MAX_REPORTS) begin
         $display("MISMATCH cycle %0d result %0d: %s got 'h%0h want 'h%0h",
                  cycle_count, results_checked, what, got, want);
      end
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // Sampling at the rising edge: transfers, checks and the cycle limit
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      conversion_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d conversions still outstanding",
                  cycle_count, pending_conversions.size());
         $display("radix_literal_to_binary verification failed");
         $finish;
      end else begin
         char_taken   <= !reset && req_bus.valid && req_bus.ready;
         result_taken <= !reset && rsp_bus.valid && rsp_bus.ready;
         // Compare a result transfer against the oldest outstanding conversion.
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_conversions.size() == 0) begin
               report_mismatch("unexpected result, value", rsp_bus.value, '0);
            end else begin
               want = pending_conversions.pop_front();
               if (rsp_bus.value !== want.value) begin
                  report_mismatch("value", rsp_bus.value, want.value);
               end
               if (rsp_bus.status !== want.status) begin
                  report_mismatch("status", 64'(rsp_bus.status), 64'(want.status));
               end
            end
            results_checked++;
            if (rsp_bus.status == rlb_pkg::ST_BAD_DIGIT) bad_digit_results++;
            if (rsp_bus.status == rlb_pkg::ST_RANGE) range_results++;
         end
         // Feed each accepted character to the predictor.
         if (!reset && req_bus.valid && req_bus.ready) begin
            chars_accepted++;
            convert_char(req_bus.char_code, req_bus.is_last);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driving at the falling edge
   // ---------------------------------------------------------------------

   function automatic int idle_cycles(input bit burst);
      return burst ? 0 : $urandom_range(0, 13);
   endfunction

   // Character driver: hold an item until its transfer, then idle for the
   // drawn gap before presenting the next one.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap       <= 0;
      end else if (!req_bus.valid || char_taken) begin
         if (req_gap != 0) begin
            req_bus.valid <= 1'b0;
            req_gap       <= req_gap - 1;
         end else if (char_queue.size() != 0) begin
            outgoing = char_queue.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.char_code <= outgoing.code;
            req_bus.is_last   <= outgoing.is_end;
            req_gap           <= idle_cycles(req_burst);
            if ($urandom_range(0, 39) == 0) req_burst <= !req_burst;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result sink: after each transfer stall for the drawn number of cycles.
   always @(negedge clock) begin
      int stall;
      if (reset) begin
         rsp_bus.ready <= 1'b1;
         rsp_stall     <= 0;
      end else if (result_taken) begin
         stall = idle_cycles(rsp_burst);
         if ($urandom_range(0, 19) == 0) rsp_burst <= !rsp_burst;
         rsp_bus.ready <= (stall == 0);
         rsp_stall     <= (stall == 0) ? 0 : stall - 1;
      end else if (rsp_stall != 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall     <= rsp_stall - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   task automatic queue_char(input logic [rlb_pkg::CHAR_W-1:0] code, input logic is_end);
      char_queue.push_back('{code: code, is_end: is_end});
      chars_pushed++;
   endtask

   // Wait until every character is in and every conversion is out, then let
   // the pipeline drain.
   task automatic settle();
      while (chars_accepted != chars_pushed || pending_conversions.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the value at the edge
   // where pready is seen high.
   task automatic write_reg(input rlb_pkg::csr_reg_type index,
                            input logic [rlb_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= rlb_pkg::CSR_ADDR_W'(4 * int'(index));
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (index == rlb_pkg::REG_RADIX) begin
         tb_radix = rlb_pkg::radix_type'(data[1:0]);
      end else begin
         tb_width = data[rlb_pkg::WIDTH_W-1:0];
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic apply_setting(input rlb_pkg::radix_type radix, input int width);
      write_reg(rlb_pkg::REG_RADIX, rlb_pkg::CSR_DATA_W'(radix));
      write_reg(rlb_pkg::REG_WIDTH, rlb_pkg::CSR_DATA_W'(width));
      setting_count++;
   endtask

   // Digit character for the current radix; letters in random case.
   function automatic logic [rlb_pkg::CHAR_W-1:0] digit_char(input int v);
      if (v < 10) return rlb_pkg::CHAR_W'("0" + v);
      return rlb_pkg::CHAR_W'(($urandom_range(0, 1) ? "A" : "a") + v - 10);
   endfunction

   // A character that is not a digit of the current radix, often a near miss.
   function automatic logic [rlb_pkg::CHAR_W-1:0] bad_char();
      logic [rlb_pkg::CHAR_W-1:0] near_miss[12] = '{"2", "8", "9", "a", "F", "g", "G", "/",
                                                    ":", "@", 8'h60, " "};
      logic [rlb_pkg::CHAR_W-1:0] c;
      logic [3:0]                 unused_digit;
      do begin
         if ($urandom_range(0, 1)) begin
            c = near_miss[$urandom_range(0, 11)];
         end else begin
            c = rlb_pkg::CHAR_W'($urandom_range(0, 255));
         end
      end while (decode_digit(c, tb_radix, unused_digit));
      return c;
   endfunction

   // One literal: mostly well formed, some with a bad character, some noise.
   task automatic queue_literal();
      logic [rlb_pkg::CHAR_W-1:0]  text[$];
      logic [rlb_pkg::VALUE_W-1:0] num;
      int                          kind;
      int                          len;
      int                          base;
      int                          long_len[4]  = '{70, 24, 21, 18};
      int                          short_len[4] = '{16, 8, 8, 6};
      kind = $urandom_range(0, 99);
      base = radix_base(tb_radix);
      if (kind < 10) begin
         // Raw bytes with random end marks; exercises the high character bits.
         repeat ($urandom_range(1, 6)) begin
            queue_char(rlb_pkg::CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
         return;
      end
      if (tb_radix == rlb_pkg::RADIX_DEC && kind < 25) begin
         // Decimal values around the signed 64-bit limit, near the unsigned top, or random.
         case ($urandom_range(0, 2))
            0:       num = rlb_pkg::DEC_LIMIT + 64'($urandom_range(0, 4)) - 64'd2;
            1:       num = ~64'd0 - 64'($urandom_range(0, 3));
            default: num = {$urandom, $urandom};
         endcase
         do begin
            text.push_front(rlb_pkg::CHAR_W'("0" + int'(num % 64'd10)));
            num = num / 64'd10;
         end while (num != 0);
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) text.push_front("0");
      end else begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, long_len[tb_radix])
                                           : $urandom_range(1, short_len[tb_radix]);
         repeat (len) text.push_back(digit_char($urandom_range(0, base - 1)));
      end
      if (kind >= 85) begin
         text[$urandom_range(0, text.size() - 1)] = bad_char();
      end
      foreach (text[k]) queue_char(text[k], k == text.size() - 1);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin
      int random_chars;
      int phase_start;
      int budget;
      int width;
      rlb_pkg::radix_type radix;

      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_bus.valid     = 1'b0;
      req_bus.char_code = '0;
      req_bus.is_last   = 1'b0;
      rsp_bus.ready     = 1'b1;
      char_taken        = 1'b0;
      result_taken      = 1'b0;
      req_gap           = 0;
      rsp_stall         = 0;
      req_burst         = 1'b0;
      rsp_burst         = 1'b0;
      tb_radix          = rlb_pkg::RADIX_DEC;
      tb_width          = rlb_pkg::WIDTH_W'(32);
      acc_value         = '0;
      acc_status        = rlb_pkg::ST_OK;
      chars_pushed      = 0;
      chars_accepted    = 0;
      results_checked   = 0;
      bad_digit_results = 0;
      range_results     = 0;
      setting_count     = 1;
      error_count       = 0;
      cycle_count       = 0;
      random_chars      = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings (decimal, 32 bits): zero, an all-ones byte, a NUL byte
      // that poisons the rest of its literal, then a plain number.
      queue_char("0", 1'b1);
      queue_char(8'hFF, 1'b1);
      queue_char(8'h00, 1'b0);
      queue_char("5", 1'b1);
      queue_char("9", 1'b0);
      queue_char("8", 1'b0);
      queue_char("7", 1'b1);
      settle();

      // Hex, full width: both letter cases at both ends of the letter range.
      apply_setting(rlb_pkg::RADIX_HEX, 64);
      queue_char("f", 1'b0);
      queue_char("F", 1'b0);
      queue_char("a", 1'b0);
      queue_char("A", 1'b0);
      queue_char("0", 1'b0);
      queue_char("9", 1'b1);
      queue_char("g", 1'b1);
      settle();

      // Binary, one bit kept: drop the upper bits; a two is not a binary digit.
      apply_setting(rlb_pkg::RADIX_BIN, 1);
      queue_char("1", 1'b0);
      queue_char("0", 1'b0);
      queue_char("1", 1'b1);
      queue_char("2", 1'b1);
      settle();

      // Octal: an eight is rejected, then the top octal digit goes through.
      apply_setting(rlb_pkg::RADIX_OCT, 33);
      queue_char("7", 1'b0);
      queue_char("8", 1'b1);
      queue_char("7", 1'b0);
      queue_char("7", 1'b1);

      // Random phases; each starts from an idle block with fresh settings.
      while (random_chars < RANDOM_CHARS) begin
         settle();
         radix = (setting_count < 8) ? rlb_pkg::radix_type'(2'(setting_count))
                                     : rlb_pkg::radix_type'(2'($urandom_range(0, 3)));
         case ($urandom_range(0, 5))
            0:       width = 1;
            1:       width = 64;
            2:       width = $urandom_range(30, 34);
            default: width = $urandom_range(1, 64);
         endcase
         apply_setting(radix, width);
         phase_start = chars_pushed;
         budget      = $urandom_range(60, 200);
         while (chars_pushed - phase_start < budget) queue_literal();
         // Sometimes leave a literal open so the next radix finishes it.
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               queue_char(digit_char($urandom_range(0, radix_base(tb_radix) - 1)), 1'b0);
            end
         end
         random_chars += chars_pushed - phase_start;
      end

      settle();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Streamed %0d characters under %0d register settings into %0d checked results,",
               chars_accepted, setting_count, results_checked);
      $display("of which %0d flagged a bad digit and %0d a decimal overflow; %0d mismatches.",
               bad_digit_results, range_results, error_count);
      if (error_count == 0 && pending_conversions.size() == 0) begin
         $display("radix_literal_to_binary verification clean");
      end else begin
         $display("radix_literal_to_binary verification failed");
      end
      $finish;
   end

endmodule
